// ===== src/cdsk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cdsk_pkg;

  localparam int unsigned CoordBits  = 16;
  localparam int unsigned DivSteps   = 30;
  localparam int unsigned RotStages  = 16;
  localparam int unsigned RemBits    = CoordBits + 1;
  localparam int unsigned RotBits    = 34;
  localparam logic [31:0] KinvQ32    = 32'h9B74EDA8;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic x_major;
    logic zero;
  } ctx_t;

  typedef struct packed {
    logic [RemBits-1:0]   rem;
    logic [CoordBits-1:0] a;
    logic [DivSteps-1:0]  q;
    ctx_t                 ctx;
  } div_t;

  typedef struct packed {
    logic signed [RotBits-1:0] x;
    logic signed [RotBits-1:0] y;
    logic signed [RotBits-1:0] z;
    ctx_t                      ctx;
  } rot_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/concentric_disk_sample_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Concentric square-to-disk mapping. A point (u_x, u_y) in unsigned Q0.16 is taken each
// cycle unless the output stalls, and its disk point appears in signed Q1.15: 30 cells
// of a pipelined restoring divider form the angle ratio, a multiplier register scales
// the radius, 16 rotation cells form cos and sin, and an output register applies signs
// and saturation. Any stall on the output side holds the whole pipeline.
module concentric_disk_sample_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] u_x_i,
  input  wire logic [15:0] u_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] disk_x_o,
  output logic signed [15:0] disk_y_o
);
  import cdsk_pkg::*;

  logic en;
  logic signed [CoordBits:0] ox;
  logic signed [CoordBits:0] oy;
  logic [CoordBits:0]        ax_w;
  logic [CoordBits:0]        ay_w;
  logic                      x_major;
  div_t                      div_in;

  logic [DivSteps:0] div_v;
  div_t              div_d [DivSteps+1];
  logic [RotStages:0] rot_v;
  rot_t               rot_d [RotStages+1];

  logic [62:0] prod;
  rot_t        mul_q;
  logic        mul_v_q;
  logic        out_v_q;
  logic [15:0] dx_q;
  logic [15:0] dy_q;

  assign en = !out_v_q || out_ready_i;

  always_comb begin
    ox      = $signed({1'b0, u_x_i}) - $signed({2'b01, {(CoordBits-1){1'b0}}});
    oy      = $signed({1'b0, u_y_i}) - $signed({2'b01, {(CoordBits-1){1'b0}}});
    ax_w    = ox[CoordBits] ? (~ox + 1'b1) : ox;
    ay_w    = oy[CoordBits] ? (~oy + 1'b1) : oy;
    x_major = ax_w > ay_w;
    div_in.a   = x_major ? ax_w[CoordBits-1:0] : ay_w[CoordBits-1:0];
    div_in.rem = x_major ? ay_w : ax_w;
    div_in.q   = '0;
    div_in.ctx.neg_x   = ox[CoordBits];
    div_in.ctx.neg_y   = oy[CoordBits];
    div_in.ctx.x_major = x_major;
    div_in.ctx.zero    = (ax_w == '0) && (ay_w == '0);
  end

  assign div_v[0] = in_valid_i;
  assign div_d[0] = div_in;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    cdsk_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[i]),
      .d_i     (div_d[i]),
      .valid_o (div_v[i+1]),
      .d_o     (div_d[i+1])
    );
  end

  // radius a<<15 in Q1.30 times the inverse rotation gain
  assign prod = {div_d[DivSteps].a, 15'b0} * KinvQ32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
    end else if (en) begin
      mul_v_q <= div_v[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q.x   <= $signed({{(RotBits-31){1'b0}}, prod[62:32]});
      mul_q.y   <= '0;
      mul_q.z   <= $signed({{(RotBits-DivSteps){1'b0}}, div_d[DivSteps].q});
      mul_q.ctx <= div_d[DivSteps].ctx;
    end
  end

  assign rot_v[0] = mul_v_q;
  assign rot_d[0] = mul_q;

  for (genvar i = 0; i < RotStages; i++) begin : g_rot
    cdsk_rot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (5'(i)),
      .valid_i (rot_v[i]),
      .d_i     (rot_d[i]),
      .valid_o (rot_v[i+1]),
      .d_o     (rot_d[i+1])
    );
  end

  function automatic logic [15:0] to_q15(input logic signed [RotBits-1:0] v, input logic neg);
    logic [RotBits-16:0] mag;
    logic [15:0]         r;
    mag = v[RotBits-1] ? '0 : v[RotBits-1:15];
    if (neg) begin
      r = (mag > 32768) ? 16'h8000 : (16'h0 - mag[15:0]);
    end else begin
      r = (mag > 32767) ? 16'h7FFF : mag[15:0];
    end
    return r;
  endfunction

  rot_t fin;
  assign fin = rot_d[RotStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= rot_v[RotStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fin.ctx.zero) begin
        dx_q <= '0;
        dy_q <= '0;
      end else if (fin.ctx.x_major) begin
        dx_q <= to_q15(fin.x, fin.ctx.neg_x);
        dy_q <= to_q15(fin.y, fin.ctx.neg_y);
      end else begin
        dx_q <= to_q15(fin.y, fin.ctx.neg_x);
        dy_q <= to_q15(fin.x, fin.ctx.neg_y);
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign disk_x_o    = $signed(dx_q);
  assign disk_y_o    = $signed(dy_q);
endmodule
`default_nettype wire

// ===== src/cdsk_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdsk_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire cdsk_pkg::div_t d_i,
  output logic               valid_o,
  output cdsk_pkg::div_t     d_o
);
  import cdsk_pkg::*;

  logic               ge;
  logic [RemBits-1:0] rem_sub;
  div_t               d_d;
  div_t               d_q;
  logic               valid_q;

  // one restoring step: quotient bit, then shift the partial remainder
  always_comb begin
    ge      = d_i.rem >= {1'b0, d_i.a};
    rem_sub = ge ? (d_i.rem - {1'b0, d_i.a}) : d_i.rem;
    d_d     = d_i;
    d_d.rem = {rem_sub[RemBits-2:0], 1'b0};
    d_d.q   = {d_i.q[DivSteps-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
endmodule
`default_nettype wire

// ===== src/cdsk_rot_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdsk_rot_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  wire logic          valid_i,
  input  wire cdsk_pkg::rot_t d_i,
  output logic               valid_o,
  output cdsk_pkg::rot_t     d_o
);
  import cdsk_pkg::*;

  logic signed [RotBits-1:0] dx;
  logic signed [RotBits-1:0] dy;
  logic signed [RotBits-1:0] ang;
  rot_t                      d_d;
  rot_t                      d_q;
  logic                      valid_q;

  always_comb begin
    dx  = d_i.y >>> idx_i;
    dy  = d_i.x >>> idx_i;
    ang = $signed({{(RotBits-32){1'b0}}, atan_turn(idx_i)});
    d_d = d_i;
    if (d_i.z >= 0) begin
      d_d.x = d_i.x - dx;
      d_d.y = d_i.y + dy;
      d_d.z = d_i.z - ang;
    end else begin
      d_d.x = d_i.x + dx;
      d_d.y = d_i.y - dy;
      d_d.z = d_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
endmodule
`default_nettype wire

// ===== src/cdsk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdsk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] disk_x_o,
  input wire logic [15:0] disk_y_o
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(disk_x_o) && $stable(disk_y_o))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled with free output");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");
endmodule

bind concentric_disk_sample_core cdsk_checker u_cdsk_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .disk_x_o    (disk_x_o),
  .disk_y_o    (disk_y_o)
);
`default_nettype wire
